[rtl/cslu_pkg.sv]
// ----------------------------------------------------------------------------
// cslu_pkg
// Types, character codes and decode functions for the C string literal
// unescaper.
// ----------------------------------------------------------------------------
package cslu_pkg;

  // Parse modes. Codes above MODE_BETWEEN are never reached and decode as
  // MODE_IN.
  typedef enum logic [3:0] {
    MODE_SKIP    = 4'd0,
    MODE_IN      = 4'd1,
    MODE_ESC     = 4'd2,
    MODE_HEX     = 4'd3,
    MODE_OCT     = 4'd4,
    MODE_BETWEEN = 4'd5
  } mode_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_OK       = 3'd1,
    KIND_NO_QUOTE = 3'd2,
    KIND_BREAK    = 3'd3,
    KIND_UNTERM   = 3'd4
  } kind_t;

  localparam int unsigned MaxResults = 3;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_V   = 8'h76;
  localparam logic [7:0] CH_LO_X   = 8'h78;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] esc_val;
    logic [1:0] digit_cnt;
    logic       done;
  } parse_state_t;

  // Up to three results produced by one request.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [MaxResults-1:0][2:0] kinds;
    logic [1:0]                 cnt;
  } bundle_t;

  typedef struct packed {
    parse_state_t st;
    bundle_t      bd;
  } work_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_oct(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= CH_ZERO) && (b <= CH_NINE)) ||
           ((b >= CH_LO_A) && (b <= CH_LO_F)) ||
           ((b >= CH_UP_A) && (b <= CH_UP_F));
  endfunction

  // Value of a hex digit; only meaningful when is_hex() holds.
  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [3:0] d;
    if (b <= CH_NINE) begin
      d = b[3:0];
    end else begin
      d = b[3:0] + 4'd9;
    end
    return d;
  endfunction

  function automatic work_t put(input work_t w, input logic [7:0] b, input kind_t k);
    work_t r;
    r = w;
    if (r.bd.cnt != 2'(MaxResults)) begin
      r.bd.bytes[r.bd.cnt] = b;
      r.bd.kinds[r.bd.cnt] = k;
      r.bd.cnt             = r.bd.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic work_t finish(input work_t w, input kind_t k);
    work_t r;
    r         = put(w, CH_NUL, k);
    r.st.done = 1'b1;
    return r;
  endfunction

  function automatic work_t clear_esc(input work_t w);
    work_t r;
    r              = w;
    r.st.esc_val   = '0;
    r.st.digit_cnt = '0;
    return r;
  endfunction

  function automatic logic [7:0] pending_val(input parse_state_t st);
    return (st.digit_cnt != 2'd0) ? st.esc_val : CH_LO_X;
  endfunction

  function automatic work_t in_literal(input work_t w, input logic [7:0] b);
    work_t r;
    r = w;
    if (b == CH_BSLASH) begin
      r.st.mode = MODE_ESC;
    end else if (b == CH_QUOTE) begin
      r.st.mode = MODE_BETWEEN;
    end else begin
      r = put(r, b, KIND_DATA);
    end
    return r;
  endfunction

  function automatic work_t end_of_buffer(input work_t w);
    work_t r;
    r = w;
    if (!r.st.done) begin
      case (r.st.mode)
        MODE_SKIP:    r = finish(r, KIND_NO_QUOTE);
        MODE_BETWEEN: r = finish(r, KIND_OK);
        MODE_HEX: begin
          r = put(r, pending_val(r.st), KIND_DATA);
          r = clear_esc(r);
          r = finish(r, KIND_UNTERM);
        end
        MODE_OCT: begin
          r = put(r, r.st.esc_val, KIND_DATA);
          r = clear_esc(r);
          r = finish(r, KIND_UNTERM);
        end
        default:      r = finish(r, KIND_UNTERM);
      endcase
    end
    return r;
  endfunction

  function automatic work_t escape_byte(input work_t w, input logic [7:0] b);
    work_t      r;
    logic [7:0] v;
    logic       emit;
    r         = w;
    v         = CH_NUL;
    emit      = 1'b1;
    r.st.mode = MODE_IN;
    case (b)
      CH_QUOTE:  v = CH_QUOTE;
      CH_LO_N:   v = 8'h0A;
      CH_LO_R:   v = 8'h0D;
      CH_LO_T:   v = 8'h09;
      CH_BSLASH: v = CH_BSLASH;
      CH_APOS:   v = CH_APOS;
      CH_LO_A:   v = 8'h07;
      CH_LO_B:   v = 8'h08;
      CH_LO_F:   v = 8'h0C;
      CH_LO_V:   v = 8'h0B;
      CH_QMARK:  v = CH_QMARK;
      default:   emit = 1'b0;
    endcase
    if ((b == CH_CR) || (b == CH_LF)) begin
      r = finish(r, KIND_BREAK);
    end else if (b == CH_LO_X) begin
      r.st.mode = MODE_HEX;
      r         = clear_esc(r);
    end else if (!emit) begin
      // Unknown escapes are dropped, octal digits open an octal escape.
      if (is_oct(b)) begin
        r.st.mode      = MODE_OCT;
        r.st.esc_val   = {5'd0, b[2:0]};
        r.st.digit_cnt = 2'd1;
      end
    end else begin
      r = put(r, v, KIND_DATA);
    end
    return r;
  endfunction

  function automatic work_t process_byte(input work_t w, input logic [7:0] b);
    work_t r;
    r = w;
    case (r.st.mode)
      MODE_SKIP: begin
        if (!is_ws(b)) begin
          if (b == CH_QUOTE) begin
            r.st.mode = MODE_IN;
          end else begin
            r = finish(r, KIND_NO_QUOTE);
          end
        end
      end
      MODE_ESC: r = escape_byte(r, b);
      MODE_HEX: begin
        if (is_hex(b) && (r.st.digit_cnt == 2'd0)) begin
          r.st.esc_val   = {4'd0, hex_digit(b)};
          r.st.digit_cnt = 2'd1;
        end else if (is_hex(b)) begin
          r         = put(r, {r.st.esc_val[3:0], hex_digit(b)}, KIND_DATA);
          r         = clear_esc(r);
          r.st.mode = MODE_IN;
        end else begin
          r         = put(r, pending_val(r.st), KIND_DATA);
          r         = clear_esc(r);
          r.st.mode = MODE_IN;
          r         = in_literal(r, b);
        end
      end
      MODE_OCT: begin
        if (is_oct(b)) begin
          r.st.esc_val   = {r.st.esc_val[4:0], b[2:0]};
          r.st.digit_cnt = r.st.digit_cnt + 2'd1;
          if (r.st.digit_cnt == 2'd3) begin
            r         = put(r, r.st.esc_val, KIND_DATA);
            r         = clear_esc(r);
            r.st.mode = MODE_IN;
          end
        end else begin
          r         = put(r, r.st.esc_val, KIND_DATA);
          r         = clear_esc(r);
          r.st.mode = MODE_IN;
          r         = in_literal(r, b);
        end
      end
      MODE_BETWEEN: begin
        if (!is_ws(b)) begin
          if (b == CH_QUOTE) begin
            r.st.mode = MODE_IN;
          end else begin
            r = finish(r, KIND_OK);
          end
        end
      end
      default: r = in_literal(r, b);
    endcase
    return r;
  endfunction

  // Whole update for one request: state in, new state and results out.
  function automatic work_t step(input parse_state_t st, input logic [7:0] b,
                                 input logic first, input logic last);
    work_t r;
    r.st = st;
    r.bd = '0;
    if (first) begin
      r.st.mode = MODE_SKIP;
      r         = clear_esc(r);
      r.st.done = 1'b0;
    end
    if (!r.st.done) begin
      if (b == CH_NUL) begin
        r = end_of_buffer(r);
      end else begin
        r = process_byte(r, b);
        if (last) begin
          r = end_of_buffer(r);
        end
      end
    end
    return r;
  endfunction

endpackage

[rtl/c_string_literal_unescaper_core.sv]
// ----------------------------------------------------------------------------
// c_string_literal_unescaper_core
// Decodes adjacent C double-quoted string literals from a raw byte stream.
// ----------------------------------------------------------------------------
// Usage:
// Raw text enters one byte per request on the in_ channel (in_data_byte,
// in_first, in_last). A request with in_first set restarts the parse. A
// zero byte or in_last closes the buffer. Decoded bytes leave on the out_
// channel as data results (out_kind data), followed by one end result
// that carries the parse status; out_last marks the final result caused
// by each request. After the end result, bytes yield nothing until the
// next in_first.
// Path: a request is captured in an input register and decoded from it
// into a result register, from which the output port presents its results.
// Throughput with out_stall low: one byte per cycle while each byte makes
// at most one result; a byte that makes k results (at most three, e.g. a
// flushed escape, the byte itself and the end status) holds the result
// register and sends them out one per cycle. Bytes that make no result
// (quotes, backslashes, whitespace) pass without touching the output.
// Stall: while out_stall is high the result register holds, and once the
// input register also holds a request that makes results, in_stall rises.
// Reset: rst_n low clears the parse state (skipping leading whitespace)
// and empties both registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module c_string_literal_unescaper_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_first,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic       out_last
);

  // Input register: one pending request.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_first_r;
  logic       in_last_r;

  // Parse state.
  cslu_pkg::parse_state_t st_r;

  // Result register: the results of one request and a read index.
  logic              bnd_vld_r;
  cslu_pkg::bundle_t bnd_r;
  logic [1:0]        idx_r;

  cslu_pkg::work_t work;
  logic            out_take;
  logic            bnd_done;
  logic            bnd_free;
  logic            move;
  logic            in_take;

  // The whole decode of one byte is a short chain of compares and muxes.
  always_comb begin
    work = cslu_pkg::step(st_r, in_byte_r, in_first_r, in_last_r);
  end

  assign out_valid = bnd_vld_r;
  assign out_byte  = bnd_r.bytes[idx_r];
  assign out_kind  = bnd_r.kinds[idx_r];
  assign out_last  = (idx_r == (bnd_r.cnt - 2'd1));

  assign out_take = bnd_vld_r && !out_stall;
  assign bnd_done = out_take && out_last;
  assign bnd_free = !bnd_vld_r || bnd_done;

  // A request with no results may retire even while the output is busy.
  assign move     = in_vld_r && (bnd_free || (work.bd.cnt == 2'd0));
  assign in_stall = in_vld_r && !move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (move) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_data_byte;
      in_first_r <= in_first;
      in_last_r  <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode      <= cslu_pkg::MODE_SKIP;
      st_r.esc_val   <= '0;
      st_r.digit_cnt <= '0;
      st_r.done      <= 1'b0;
    end else if (move) begin
      st_r <= work.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (move && (work.bd.cnt != 2'd0)) begin
      bnd_vld_r <= 1'b1;
      idx_r     <= '0;
    end else if (bnd_done) begin
      bnd_vld_r <= 1'b0;
    end else if (out_take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move && (work.bd.cnt != 2'd0)) begin
      bnd_r <= work.bd;
    end
  end

endmodule
